// ----- hw/rtl/tcw_pkg.sv -----
// shared constants, item types and helper functions of the text console writer
package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int AW      = $clog2(CELLS);

	localparam int XW = 7;   // cursor column width
	localparam int YW = 5;   // cursor row width
	localparam int OW = 11;  // cursor offset width
	localparam int CW = 5;   // scroll_rows register width

	localparam logic [15:0] BLANK_CELL   = 16'h0e20;
	localparam logic [7:0]  SPACE_CHAR   = 8'h20;
	localparam logic [7:0]  NEWLINE_CHAR = 8'h0a;
	localparam logic [7:0]  NULL_CHAR    = 8'h00;
	localparam logic [CW-1:0] SCROLL_ROWS_RESET = 5'd24;

	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_SET   = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	typedef struct packed {
		logic [1:0]    action;
		logic [7:0]    char_code;
		logic [7:0]    attr;
		logic [XW-1:0] col_x;
		logic [YW-1:0] row_y;
	} cmd_t;

	// packed so that cursor_col sits in the lowest bits
	typedef struct packed {
		logic          scrolled;
		logic [7:0]    read_attr;
		logic [7:0]    read_char;
		logic [OW-1:0] cursor_offset;
		logic [YW-1:0] cursor_row;
		logic [XW-1:0] cursor_col;
	} res_t;

	function automatic logic [XW-1:0] sat_col(input logic [XW-1:0] v);
		return (v > XW'(COLUMNS - 1)) ? XW'(COLUMNS - 1) : v;
	endfunction

	function automatic logic [YW-1:0] sat_row(input logic [YW-1:0] v);
		return (v > YW'(ROWS - 1)) ? YW'(ROWS - 1) : v;
	endfunction

	// zero acts as one, anything above the screen height as the height
	function automatic logic [CW-1:0] limit_rows(input logic [CW-1:0] r);
		logic [CW-1:0] l;
		l = r;
		if (r == '0) l = CW'(1);
		if ({1'b0, r} > (CW + 1)'(ROWS)) l = CW'(ROWS);
		return l;
	endfunction

	function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
		logic [AW-1:0] row_base;
		row_base = AW'(AW'(y) * AW'(COLUMNS));
		return AW'(row_base + AW'(x));
	endfunction

endpackage

// ----- hw/rtl/tcw_cell_ram.sv -----
// simple dual port cell memory, one write and one registered read per cycle
module tcw_cell_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/tcw_seq.sv -----
// command sequencer: cursor, cell writes, scroll and clear sweeps over the cell memory
module tcw_seq import tcw_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [CW-1:0] scroll_rows,
	input  logic          start,
	input  cmd_t          cmd,
	output logic          ready,
	output logic          res_valid,
	input  logic          res_ack,
	output res_t          res
);

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_READ   = 3'd2;
	localparam logic [2:0] ST_SCROLL = 3'd3;
	localparam logic [2:0] ST_CLEAR  = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]    state_q;
	logic [XW-1:0] cur_x_q;
	logic [YW-1:0] cur_y_q;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] last_q;
	logic [AW-1:0] copy_q;
	logic [7:0]    rchar_q;
	logic [7:0]    rattr_q;
	logic          scrolled_q;

	logic          wr_valid_s1;
	logic [AW-1:0] wr_addr_s1;
	logic          wr_blank_s1;

	logic          accept;
	logic [CW-1:0] lim;
	logic [AW-1:0] area_last;
	logic [AW-1:0] copy_end;
	logic [XW:0]   x_inc;
	logic          wrap;
	logic [YW:0]   y_inc;
	logic          hit;
	logic          printable;
	logic          row_step;
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] cur_lin;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;

	assign ready  = (state_q == ST_IDLE);
	assign accept = ready && start;

	assign lim       = limit_rows(scroll_rows);
	assign area_last = AW'(AW'(lim) * AW'(COLUMNS) - AW'(1));
	assign copy_end  = AW'(AW'(lim - CW'(1)) * AW'(COLUMNS));

	assign x_inc     = {1'b0, cur_x_q} + (XW + 1)'(1);
	assign wrap      = x_inc >= (XW + 1)'(COLUMNS);
	assign y_inc     = {1'b0, cur_y_q} + (YW + 1)'(1);
	assign hit       = y_inc >= (YW + 1)'(lim);
	assign printable = (cmd.char_code != NULL_CHAR) && (cmd.char_code != NEWLINE_CHAR);
	assign row_step  = (cmd.char_code == NEWLINE_CHAR) || (printable && wrap);
	assign cur_addr  = cell_addr(cur_x_q, cur_y_q);

	// memory port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_addr;
		ram_wdata = {cmd.attr, cmd.char_code};
		if (state_q == ST_INIT || state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q;
			ram_wdata = BLANK_CELL;
		end else if (wr_valid_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wr_addr_s1;
			ram_wdata = wr_blank_s1 ? {ram_rdata[15:8], SPACE_CHAR} : ram_rdata;
		end else if (accept && cmd.action == ACT_PUT && printable) begin
			ram_we = 1'b1;
		end
	end

	// scroll copies each row from the one below, the last row of the area keeps its attributes
	always_comb begin
		if (state_q == ST_SCROLL) begin
			ram_raddr = (cnt_q < copy_q) ? AW'(cnt_q + AW'(COLUMNS)) : cnt_q;
		end else begin
			ram_raddr = cell_addr(sat_col(cmd.col_x), sat_row(cmd.row_y));
		end
	end

	tcw_cell_ram #(
		.WIDTH(16),
		.DEPTH(CELLS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// write-back stage of the scroll sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_s1 <= 1'b0;
			wr_addr_s1  <= '0;
			wr_blank_s1 <= 1'b0;
		end else begin
			wr_valid_s1 <= (state_q == ST_SCROLL);
			wr_addr_s1  <= cnt_q;
			wr_blank_s1 <= !(cnt_q < copy_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			cnt_q      <= '0;
			last_q     <= '0;
			copy_q     <= '0;
			rchar_q    <= '0;
			rattr_q    <= '0;
			scrolled_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					if (cnt_q == AW'(CELLS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= AW'(cnt_q + AW'(1));
					end
				end
				ST_IDLE: begin
					if (accept) begin
						rchar_q    <= '0;
						rattr_q    <= '0;
						scrolled_q <= (cmd.action == ACT_PUT) && row_step && hit;
						cnt_q      <= '0;
						last_q     <= area_last;
						copy_q     <= copy_end;
						case (cmd.action)
							ACT_PUT: begin
								if (row_step) begin
									cur_x_q <= '0;
									if (hit) begin
										state_q <= ST_SCROLL;
									end else begin
										cur_y_q <= y_inc[YW-1:0];
										state_q <= ST_DONE;
									end
								end else begin
									state_q <= ST_DONE;
									if (printable) begin
										cur_x_q <= x_inc[XW-1:0];
									end
								end
							end
							ACT_SET: begin
								cur_x_q <= sat_col(cmd.col_x);
								cur_y_q <= sat_row(cmd.row_y);
								state_q <= ST_DONE;
							end
							ACT_CLEAR: begin
								cur_x_q <= '0;
								cur_y_q <= '0;
								state_q <= ST_CLEAR;
							end
							default: begin
								state_q <= ST_READ;
							end
						endcase
					end
				end
				ST_READ: begin
					rchar_q <= ram_rdata[7:0];
					rattr_q <= ram_rdata[15:8];
					state_q <= ST_DONE;
				end
				ST_SCROLL, ST_CLEAR: begin
					cnt_q <= AW'(cnt_q + AW'(1));
					if (cnt_q == last_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cur_lin   = cell_addr(cur_x_q, cur_y_q);
	assign res_valid = (state_q == ST_DONE);

	always_comb begin
		res.scrolled      = scrolled_q;
		res.read_attr     = rattr_q;
		res.read_char     = rchar_q;
		res.cursor_offset = OW'(cur_lin);
		res.cursor_row    = cur_y_q;
		res.cursor_col    = cur_x_q;
	end

endmodule

// ----- hw/rtl/text_console_writer.sv -----
// top level of the text console writer: stream ports, scroll register and result register
//
// Text console over an 80x25 character/attribute store held in one simple dual port
// memory. After reset the block blanks all 2000 cells, one per cycle, and holds
// s_axis_tready low until they are done; cfg writes are taken at any time. Each item
// passes through a sequencer that owns the memory ports: a put, set cursor or ignored
// character goes from idle straight to the done state, a read cell first passes a read
// state for the registered memory read. A put that runs past the last scroll row and a
// clear both sweep the scroll area one cell per cycle. One result item leaves per input
// item through an output register, so the next item is taken while a result waits.
module text_console_writer import tcw_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// char_code[7:0], attr[15:8], col_x[22:16], row_y[27:23], zeros[31:28]
	input  logic [31:0]   s_axis_tdata,
	// action[1:0]
	input  logic [1:0]    s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// cursor_col[6:0], cursor_row[11:7], cursor_offset[22:12], read_char[30:23],
	// read_attr[38:31], scrolled[39]
	output logic [39:0]   m_axis_tdata,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [CW-1:0] cfg_data
);

	logic [CW-1:0] scroll_rows_q;
	logic          m_valid_q;
	res_t          m_data_q;
	cmd_t          cmd;
	logic          seq_ready;
	logic          res_valid;
	logic          res_ack;
	res_t          res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_rows_q <= SCROLL_ROWS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			scroll_rows_q <= cfg_data;
		end
	end

	always_comb begin
		cmd.action    = s_axis_tuser;
		cmd.char_code = s_axis_tdata[7:0];
		cmd.attr      = s_axis_tdata[15:8];
		cmd.col_x     = s_axis_tdata[22:16];
		cmd.row_y     = s_axis_tdata[27:23];
	end

	tcw_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.scroll_rows(scroll_rows_q),
		.start      (s_axis_tvalid),
		.cmd        (cmd),
		.ready      (seq_ready),
		.res_valid  (res_valid),
		.res_ack    (res_ack),
		.res        (res)
	);

	assign s_axis_tready = seq_ready;

	// result moves into the output register once it is empty or being drained
	assign res_ack = res_valid && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ack) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack) begin
			m_data_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

// ----- hw/rtl/tcw_checker.sv -----
// port-level checks of the text console writer and their binding to the top level
module tcw_checker import tcw_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);

	logic [XW-1:0] col;
	logic [YW-1:0] row;
	logic [OW-1:0] offset;
	logic          scrolled;
	logic [AW-1:0] lin;

	assign col      = m_axis_tdata[6:0];
	assign row      = m_axis_tdata[11:7];
	assign offset   = m_axis_tdata[22:12];
	assign scrolled = m_axis_tdata[39];
	assign lin      = cell_addr(col, row);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (col <= XW'(COLUMNS - 1)) && (row <= YW'(ROWS - 1)))
		else $error("cursor outside the screen");

	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> offset == OW'(lin))
		else $error("cursor offset does not match column and row");

	a_scroll_col: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && scrolled |-> col == '0)
		else $error("scroll reported with cursor off column zero");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

// ----- dv/tb_text_console_writer.sv -----
// testbench for the text console writer: directed and random items checked against a predictor
module tb_text_console_writer;
	import tcw_pkg::*;

	logic          clk;
	logic          arst_n;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [31:0]   s_axis_tdata;
	logic [1:0]    s_axis_tuser;
	logic          m_axis_tvalid;
	logic          m_axis_tready;
	logic [39:0]   m_axis_tdata;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [CW-1:0] cfg_data;

	text_console_writer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// predictor state
	logic [15:0]   screen [CELLS];
	int            cur_x;
	int            cur_y;
	logic [CW-1:0] scroll_reg;
	res_t          cursor_reports_due [$];

	int errors;
	bit src_steady;
	bit sink_steady;
	bit hold_results;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(string what, int got, int want);
		if (errors < 40)
			$display("mismatch on %s: got %0d, want %0d", what, got, want);
		errors++;
	endtask

	function automatic int active_rows();
		int r;
		r = int'(scroll_reg);
		if (r < 1) r = 1;
		if (r > ROWS) r = ROWS;
		return r;
	endfunction

	// move the cursor down a row, scrolling the active area when it runs past the end
	function automatic bit line_feed();
		int n;
		n = active_rows();
		cur_y++;
		if (cur_y < n) return 1'b0;
		for (int i = 0; i + COLUMNS < n * COLUMNS; i++)
			screen[i] = screen[i + COLUMNS];
		for (int i = (n - 1) * COLUMNS; i < n * COLUMNS; i++)
			screen[i] = {screen[i][15:8], SPACE_CHAR};
		cur_y--;
		return 1'b1;
	endfunction

	function automatic res_t apply_console_item(cmd_t c);
		res_t r;
		int cx;
		int cy;
		logic [15:0] cell_word;
		r = '0;
		cx = (int'(c.col_x) > COLUMNS - 1) ? COLUMNS - 1 : int'(c.col_x);
		cy = (int'(c.row_y) > ROWS - 1) ? ROWS - 1 : int'(c.row_y);
		case (c.action)
			ACT_PUT: begin
				if (c.char_code == NEWLINE_CHAR) begin
					cur_x = 0;
					r.scrolled = line_feed();
				end else if (c.char_code != NULL_CHAR) begin
					screen[cur_x + COLUMNS * cur_y] = {c.attr, c.char_code};
					cur_x++;
					if (cur_x >= COLUMNS) begin
						cur_x = 0;
						r.scrolled = line_feed();
					end
				end
			end
			ACT_SET: begin
				cur_x = cx;
				cur_y = cy;
			end
			ACT_CLEAR: begin
				for (int i = 0; i < active_rows() * COLUMNS; i++)
					screen[i] = BLANK_CELL;
				cur_x = 0;
				cur_y = 0;
			end
			ACT_READ: begin
				cell_word = screen[cx + COLUMNS * cy];
				r.read_char = cell_word[7:0];
				r.read_attr = cell_word[15:8];
			end
		endcase
		r.cursor_col    = XW'(cur_x);
		r.cursor_row    = YW'(cur_y);
		r.cursor_offset = OW'(cur_y * COLUMNS + cur_x);
		return r;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// called at a falling edge, returns at a falling edge with tvalid still high
	task automatic send_item(cmd_t c);
		int gap;
		gap = (src_steady || $urandom_range(0, 99) < 45) ? 0 : gap_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0000, c.row_y, c.col_x, c.attr, c.char_code};
		s_axis_tuser  <= c.action;
		do @(posedge clk); while (!s_axis_tready);
		cursor_reports_due.push_back(apply_console_item(c));
		@(negedge clk);
	endtask

	task automatic send_fields(logic [1:0] act, logic [7:0] ch, logic [7:0] at,
			logic [XW-1:0] x, logic [YW-1:0] y);
		cmd_t c;
		c.action    = act;
		c.char_code = ch;
		c.attr      = at;
		c.col_x     = x;
		c.row_y     = y;
		send_item(c);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (cursor_reports_due.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_scroll_rows(logic [CW-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		scroll_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic cmd_t random_item();
		cmd_t c;
		int pick;
		c = cmd_t'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 68) begin
			c.action = ACT_PUT;
			pick = $urandom_range(0, 99);
			if (pick < 12) c.char_code = NEWLINE_CHAR;
			else if (pick < 15) c.char_code = NULL_CHAR;
		end else if (pick < 80) begin
			c.action = ACT_SET;
			if ($urandom_range(0, 4) != 0) begin
				c.col_x = XW'($urandom_range(0, COLUMNS - 1));
				c.row_y = YW'($urandom_range(0, ROWS - 1));
			end
		end else if (pick < 83) begin
			c.action = ACT_CLEAR;
		end else begin
			c.action = ACT_READ;
		end
		return c;
	endfunction

	task automatic test_put_edges();
		send_fields(ACT_PUT, 8'h41, 8'h00, '0, '0);
		send_fields(ACT_PUT, 8'hff, 8'hff, '1, '1);
		send_fields(ACT_PUT, NULL_CHAR, 8'h55, 7'd3, 5'd3);
		send_fields(ACT_PUT, NEWLINE_CHAR, 8'haa, 7'd9, 5'd9);
		send_fields(ACT_SET, 8'h00, 8'h00, 7'd79, 5'd2);
		// last column wraps to the next row
		send_fields(ACT_PUT, 8'h01, 8'h80, '0, '0);
		wait_idle();
	endtask

	task automatic test_cursor_and_read();
		send_fields(ACT_SET, 8'h00, 8'h00, 7'd127, 5'd31);
		send_fields(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0);
		send_fields(ACT_READ, 8'h00, 8'h00, 7'd1, 5'd0);
		send_fields(ACT_READ, 8'hff, 8'hff, 7'd127, 5'd31);
		send_fields(ACT_READ, 8'h00, 8'h00, 7'd79, 5'd2);
		wait_idle();
	endtask

	task automatic test_scroll_and_clear();
		send_fields(ACT_SET, 8'h00, 8'h00, 7'd0, 5'd23);
		send_fields(ACT_PUT, NEWLINE_CHAR, 8'h07, '0, '0);
		// cursor parked below the scroll area
		send_fields(ACT_SET, 8'h00, 8'h00, 7'd5, 5'd24);
		send_fields(ACT_PUT, 8'h78, 8'h1f, '0, '0);
		send_fields(ACT_SET, 8'h00, 8'h00, 7'd79, 5'd24);
		send_fields(ACT_PUT, 8'h7a, 8'h2e, '0, '0);
		send_fields(ACT_READ, 8'h00, 8'h00, 7'd5, 5'd24);
		send_fields(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd22);
		send_fields(ACT_CLEAR, 8'h00, 8'h00, '0, '0);
		send_fields(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0);
		send_fields(ACT_READ, 8'h00, 8'h00, 7'd5, 5'd24);
		wait_idle();
	endtask

	task automatic test_random_traffic(logic [CW-1:0] rows, int count);
		int sent;
		int len;
		cmd_t c;
		write_scroll_rows(rows);
		src_steady  = ($urandom_range(0, 3) == 0);
		sink_steady = ($urandom_range(0, 3) == 0);
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 1) == 0) begin
				// a line of printable text, often ended by a newline
				len = $urandom_range(1, 100);
				if (len > count - sent) len = count - sent;
				repeat (len) begin
					c = cmd_t'($urandom);
					c.action = ACT_PUT;
					c.char_code = 8'($urandom_range(32, 126));
					send_item(c);
				end
				sent += len;
				if ($urandom_range(0, 1) == 0) begin
					c = cmd_t'($urandom);
					c.action = ACT_PUT;
					c.char_code = NEWLINE_CHAR;
					send_item(c);
					sent++;
				end
			end else begin
				send_item(random_item());
				sent++;
			end
		end
		wait_idle();
		src_steady  = 1'b0;
		sink_steady = 1'b0;
	endtask

	task automatic test_result_backpressure();
		cmd_t c;
		write_scroll_rows(5'd3);
		src_steady   = 1'b1;
		hold_results = 1'b1;
		repeat (24) begin
			c = cmd_t'($urandom);
			c.action = ($urandom_range(0, 3) == 0) ? ACT_READ : ACT_PUT;
			send_item(c);
		end
		wait_idle();
		src_steady = 1'b0;
	endtask

	// result sink with random stalls and one long hold-off on request
	initial begin : result_sink
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_results) begin
				m_axis_tready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_results = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (sink_steady || $urandom_range(0, 2) != 0) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				repeat (gap_len() - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_results
		res_t got;
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = res_t'(m_axis_tdata);
			if (cursor_reports_due.size() == 0) begin
				report_mismatch("result with nothing pending", int'(got.cursor_offset), -1);
			end else begin
				want = cursor_reports_due.pop_front();
				if (got.cursor_col != want.cursor_col)
					report_mismatch("cursor_col", got.cursor_col, want.cursor_col);
				if (got.cursor_row != want.cursor_row)
					report_mismatch("cursor_row", got.cursor_row, want.cursor_row);
				if (got.cursor_offset != want.cursor_offset)
					report_mismatch("cursor_offset", got.cursor_offset, want.cursor_offset);
				if (got.read_char != want.read_char)
					report_mismatch("read_char", got.read_char, want.read_char);
				if (got.read_attr != want.read_attr)
					report_mismatch("read_attr", got.read_attr, want.read_attr);
				if (got.scrolled != want.scrolled)
					report_mismatch("scrolled", got.scrolled, want.scrolled);
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		errors        = 0;
		src_steady    = 1'b0;
		sink_steady   = 1'b0;
		hold_results  = 1'b0;
		foreach (screen[i]) screen[i] = BLANK_CELL;
		cur_x = 0;
		cur_y = 0;
		scroll_reg = SCROLL_ROWS_RESET;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_put_edges();
		test_cursor_and_read();
		test_scroll_and_clear();
		test_result_backpressure();
		test_random_traffic(5'd24, 130);
		test_random_traffic(5'd1, 130);
		test_random_traffic(5'd0, 130);
		test_random_traffic(5'd25, 130);
		test_random_traffic(5'd31, 130);
		test_random_traffic(5'd2, 130);
		test_random_traffic(5'd12, 130);
		test_random_traffic(CW'($urandom_range(0, 31)), 130);

		if (cursor_reports_due.size() != 0)
			report_mismatch("results never received", cursor_reports_due.size(), 0);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_cell_ram.sv
hw/rtl/tcw_seq.sv
hw/rtl/text_console_writer.sv
hw/rtl/tcw_checker.sv
dv/tb_text_console_writer.sv
